// ===== src/u2d_pkg.sv =====
package u2d_pkg;

    localparam int VALUE_W     = 64;   // widest operand
    localparam int WSEL_W      = 2;    // width select code
    localparam int CHAR_W      = 6;    // ASCII digit code
    localparam int IN_DATA_W   = 64;   // value, already whole bytes
    localparam int OUT_DATA_W  = 8;    // digit_char, filled to a byte
    localparam int FULL_DIGITS = 20;   // decimal digits of the widest operand
    localparam int MAX_DIGITS_DEF = FULL_DIGITS;
    localparam int STEP_W      = $clog2(VALUE_W + 1);
    localparam int Q_DEPTH     = 2;
    localparam int Q_IW        = $clog2(Q_DEPTH);
    localparam int Q_CW        = $clog2(Q_DEPTH + 1);

    localparam logic [CHAR_W-1:0] ASCII_ZERO  = 6'd48;
    localparam logic [3:0]        BCD_ADJ_MIN = 4'd5;
    localparam logic [3:0]        BCD_ADJ     = 4'd3;

    typedef enum logic [WSEL_W-1:0] {
        WSEL_8  = 2'd0,
        WSEL_16 = 2'd1,
        WSEL_32 = 2'd2,
        WSEL_64 = 2'd3
    } t_wsel;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_CONV,
        BK_EMIT
    } t_bk_state;

    // One classified operand: left-aligned bits and the number of shift steps.
    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic [STEP_W-1:0]  steps;
    } t_q_item;

endpackage

// ===== src/unsigned_to_decimal_ascii.sv =====
// Channel   Dir  Payload                                   Handshake
// s (in)    in   tdata[63:0]=value, tuser[1:0]=width_sel   i_s_tvalid / o_s_tready
// m (out)   out  tdata[5:0]=digit_char, [7:6]=0, tlast     o_m_tvalid / i_m_tready
//
// Per item: the item leaves the queue, then 8, 16, 32 or 64 shift steps
// (one per operand bit), then the digits are emitted one at a time, most
// significant first. Synchronous active-low reset clears the control state
// but for the digit index. A two-entry queue takes new items while the back
// end works, and the output register holds a digit while the sink stalls.
module unsigned_to_decimal_ascii
    import u2d_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_s_tvalid,
    output logic                   o_s_tready,
    input  logic [IN_DATA_W-1:0]   i_s_tdata,   // [63:0] value
    input  logic [WSEL_W-1:0]      i_s_tuser,   // [1:0] width_select
    output logic                   o_m_tvalid,
    input  logic                   i_m_tready,
    output logic [OUT_DATA_W-1:0]  o_m_tdata,   // [5:0] digit_char, [7:6] zero
    output logic                   o_m_tlast    // last digit of the number
);

    logic              push;
    t_q_item           push_item;
    logic              q_ready;
    logic              q_valid;
    t_q_item           q_item;
    logic              q_pop;
    logic [CHAR_W-1:0] out_char;

    // Classify: truncate to the selected width and count the shift steps.
    u2d_front u_front (
        .i_valid   (i_s_tvalid),
        .o_ready   (o_s_tready),
        .i_value   (i_s_tdata),
        .i_wsel    (i_s_tuser),
        .o_push    (push),
        .o_item    (push_item),
        .i_q_ready (q_ready)
    );

    // Hold classified items until the converter is free.
    u2d_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (push_item),
        .o_ready (q_ready),
        .o_valid (q_valid),
        .o_item  (q_item),
        .i_pop   (q_pop)
    );

    // Convert to decimal digits, then emit most significant digit first.
    u2d_back #(
        .MAX_DIGITS (MAX_DIGITS)
    ) u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_valid (q_valid),
        .i_q_item  (q_item),
        .o_q_pop   (q_pop),
        .o_valid   (o_m_tvalid),
        .i_ready   (i_m_tready),
        .o_char    (out_char),
        .o_last    (o_m_tlast)
    );

    assign o_m_tdata = {2'b00, out_char};

endmodule

// ===== src/u2d_front.sv =====
module u2d_front
    import u2d_pkg::*;
(
    input  logic                  i_valid,
    output logic                  o_ready,
    input  logic [VALUE_W-1:0]    i_value,
    input  logic [WSEL_W-1:0]     i_wsel,
    output logic                  o_push,
    output t_q_item               o_item,
    input  logic                  i_q_ready
);

    // Align the selected width to the top; the bits above it fall off.
    always_comb begin
        o_item = '0;
        unique case (t_wsel'(i_wsel))
            WSEL_8: begin
                o_item.value = {i_value[7:0], 56'd0};
                o_item.steps = STEP_W'(8);
            end
            WSEL_16: begin
                o_item.value = {i_value[15:0], 48'd0};
                o_item.steps = STEP_W'(16);
            end
            WSEL_32: begin
                o_item.value = {i_value[31:0], 32'd0};
                o_item.steps = STEP_W'(32);
            end
            default: begin
                o_item.value = i_value;
                o_item.steps = STEP_W'(VALUE_W);
            end
        endcase
    end

    assign o_ready = i_q_ready;
    assign o_push  = i_valid & i_q_ready;

endmodule

// ===== src/u2d_queue.sv =====
module u2d_queue
    import u2d_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_q_item i_item,
    output logic    o_ready,
    output logic    o_valid,
    output t_q_item o_item,
    input  logic    i_pop
);

    t_q_item           r_item [Q_DEPTH];
    logic [Q_IW-1:0]   r_wr, n_wr;
    logic [Q_IW-1:0]   r_rd, n_rd;
    logic [Q_CW-1:0]   r_cnt, n_cnt;
    logic              do_push, do_pop;

    assign o_ready = (r_cnt != Q_CW'(Q_DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_item  = r_item[r_rd];
    assign do_push = i_push & o_ready;
    assign do_pop  = i_pop & o_valid;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == Q_IW'(Q_DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == Q_IW'(Q_DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (do_push && !do_pop) begin
            n_cnt = r_cnt + 1'b1;
        end else if (do_pop && !do_push) begin
            n_cnt = r_cnt - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_item[r_wr] <= i_item;
        end
    end

endmodule

// ===== src/u2d_back.sv =====
module u2d_back
    import u2d_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_valid,
    input  t_q_item               i_q_item,
    output logic                  o_q_pop,
    output logic                  o_valid,
    input  logic                  i_ready,
    output logic [CHAR_W-1:0]     o_char,
    output logic                  o_last
);

    localparam int BCD_W = 4 * MAX_DIGITS;
    localparam int CW    = $clog2(MAX_DIGITS + 1);
    localparam int IW    = $clog2(MAX_DIGITS);

    t_bk_state                      r_state, n_state;
    logic [VALUE_W-1:0]             r_shift, n_shift;
    logic [STEP_W-1:0]              r_steps, n_steps;
    logic [MAX_DIGITS-1:0][3:0]     r_bcd, n_bcd;
    logic [MAX_DIGITS-1:0]          r_sig, n_sig;
    logic [CW-1:0]                  r_cnt, n_cnt;
    logic [IW-1:0]                  r_idx, n_idx;
    logic                           r_out_valid, n_out_valid;
    logic [CHAR_W-1:0]              r_out_char, n_out_char;
    logic                           r_out_last, n_out_last;

    logic [MAX_DIGITS-1:0][3:0]     adj;
    logic [BCD_W-1:0]               adj_flat;
    logic [MAX_DIGITS-1:0][3:0]     conv_bcd;
    logic [MAX_DIGITS-1:0]          conv_sig;
    logic [CW-1:0]                  conv_cnt;
    logic                           last_step;
    logic                           out_free;
    logic                           load;

    // Double dabble lanes: correct each digit, then shift one operand bit in.
    // Digits above the kept range drop off, which leaves the value mod 10^N.
    always_comb begin
        for (int k = 0; k < MAX_DIGITS; k++) begin
            adj[k] = (r_bcd[k] >= BCD_ADJ_MIN) ? r_bcd[k] + BCD_ADJ : r_bcd[k];
        end
        adj_flat = adj;
        conv_bcd = {adj_flat[BCD_W-2:0], r_shift[VALUE_W-1]};
        for (int k = 0; k < MAX_DIGITS; k++) begin
            conv_sig[k] = r_sig[k] | (conv_bcd[k] != 4'd0);
        end
        // the digit count grows by one at most per step
        conv_cnt = r_cnt + CW'(|(conv_sig & ~r_sig));
    end

    assign last_step = (r_steps == STEP_W'(1));
    assign out_free  = !r_out_valid || i_ready;
    assign load      = (r_state == BK_EMIT) && out_free;
    assign o_q_pop   = (r_state == BK_IDLE) && i_q_valid;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            BK_IDLE: if (i_q_valid) n_state = BK_CONV;
            BK_CONV: if (last_step) n_state = BK_EMIT;
            BK_EMIT: if (load && r_idx == '0) n_state = BK_IDLE;
            default: n_state = BK_IDLE;
        endcase
    end

    always_comb begin
        n_shift     = r_shift;
        n_steps     = r_steps;
        n_bcd       = r_bcd;
        n_sig       = r_sig;
        n_cnt       = r_cnt;
        n_idx       = r_idx;
        n_out_valid = r_out_valid & ~i_ready;
        n_out_char  = r_out_char;
        n_out_last  = r_out_last;
        unique case (r_state)
            BK_IDLE: begin
                n_shift = i_q_item.value;
                n_steps = i_q_item.steps;
                n_bcd   = '0;
                n_sig   = '0;
                n_cnt   = '0;
            end
            BK_CONV: begin
                n_shift = {r_shift[VALUE_W-2:0], 1'b0};
                n_steps = r_steps - 1'b1;
                n_bcd   = conv_bcd;
                n_sig   = conv_sig;
                n_cnt   = conv_cnt;
                // a value of zero still emits one digit
                n_idx   = (conv_cnt == '0) ? '0 : IW'(conv_cnt - 1'b1);
            end
            BK_EMIT: begin
                if (load) begin
                    n_out_valid = 1'b1;
                    n_out_char  = ASCII_ZERO + {2'b00, r_bcd[r_idx]};
                    n_out_last  = (r_idx == '0);
                    n_idx       = r_idx - 1'b1;
                end
            end
            default: begin
                n_idx = r_idx;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
            r_steps     <= '0;
            r_cnt       <= '0;
            r_shift     <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_steps     <= n_steps;
            r_cnt       <= n_cnt;
            r_shift     <= n_shift;
        end
    end

    always_ff @(posedge i_clk) begin
        r_bcd      <= n_bcd;
        r_sig      <= n_sig;
        r_idx      <= n_idx;
        r_out_char <= n_out_char;
        r_out_last <= n_out_last;
    end

    assign o_valid = r_out_valid;
    assign o_char  = r_out_char;
    assign o_last  = r_out_last;

endmodule

// ===== src/u2d_checker.sv =====
module u2d_checker
    import u2d_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_m_tvalid,
    input  logic                   i_m_tready,
    input  logic [OUT_DATA_W-1:0]  i_m_tdata,
    input  logic                   i_m_tlast
);

    logic r_first;

    // Track whether the next digit opens a new number.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= 1'b1;
        end else if (i_m_tvalid && i_m_tready) begin
            r_first <= i_m_tlast;
        end
    end

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid && !i_m_tready |=>
            i_m_tvalid && $stable(i_m_tdata) && $stable(i_m_tlast))
        else $error("output digit changed while stalled");

    a_digit_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_m_tvalid |-> (i_m_tdata[7:4] == 4'b0011) && (i_m_tdata[3:0] <= 4'd9))
        else $error("output is not an ASCII decimal digit");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_m_tvalid)
        else $error("output valid right after reset");

    a_no_lead_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (MAX_DIGITS == FULL_DIGITS) && i_m_tvalid && r_first &&
            (i_m_tdata[5:0] == ASCII_ZERO) |-> i_m_tlast)
        else $error("leading zero digit emitted");

endmodule

bind unsigned_to_decimal_ascii u2d_checker #(
    .MAX_DIGITS (MAX_DIGITS)
) u_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .i_m_tdata  (o_m_tdata),
    .i_m_tlast  (o_m_tlast)
);
